// File: sv/sparse_table_range_minimum_top_macros.svh
// assertion macros used by the checker file
`ifndef SPARSE_TABLE_RANGE_MINIMUM_TOP_MACROS_SVH
`define SPARSE_TABLE_RANGE_MINIMUM_TOP_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/strm_pkg.sv
`default_nettype none

package strm_pkg;

   // sizing of the table
   localparam int MAX_ELEMENTS = 1024;
   localparam int LEVELS       = 11;
   localparam int VALUE_WIDTH  = 32;

   localparam int IDX_W     = $clog2(MAX_ELEMENTS);
   localparam int COUNT_W   = IDX_W + 1;
   localparam int LVL_AW    = $clog2(LEVELS);
   localparam int LEVEL_W   = $clog2(LEVELS + 1);
   localparam int ADDR_W    = LVL_AW + IDX_W;
   localparam int SUM_W     = COUNT_W + 2;
   localparam int RAM_DEPTH = LEVELS * MAX_ELEMENTS;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_LOAD   = CMD_W'(0);
   localparam logic [CMD_W-1:0] CMD_BUILD  = CMD_W'(1);
   localparam logic [CMD_W-1:0] CMD_QUERY  = CMD_W'(2);
   localparam logic [CMD_W-1:0] CMD_UNUSED = CMD_W'(3);

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] ST_NOT_BUILT = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] ST_BAD       = STATUS_W'(2);

   typedef struct packed {
      logic [CMD_W-1:0]              command;
      logic [IDX_W-1:0]              element_index;
      logic signed [VALUE_WIDTH-1:0] element_value;
      logic [IDX_W-1:0]              range_start;
      logic [IDX_W-1:0]              range_end;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] minimum;
      logic [STATUS_W-1:0]           status;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic                load_write;
      logic                build_start;
      logic                build_read;
      logic                build_write;
      logic                rsp_load;
      logic                rsp_take_min;
      logic [STATUS_W-1:0] rsp_status;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic load_ok;
      logic range_ok;
      logic level_ok;
   } dp_status_type;

   // position of the highest set bit
   function automatic logic [LEVEL_W-1:0] floor_log2(input logic [COUNT_W-1:0] v);
      logic [LEVEL_W-1:0] k;
      k = '0;
      for (int i = 0; i < COUNT_W; i++) begin
         if (v[i]) begin
            k = LEVEL_W'(i);
         end
      end
      return k;
   endfunction

endpackage

`default_nettype wire

// File: sv/strm_ram.sv
`default_nettype none

module strm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
   output logic      [WIDTH-1:0]         rdata_a,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic      [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule

`default_nettype wire

// File: sv/strm_ctrl.sv
`default_nettype none

module strm_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic [strm_pkg::CMD_W-1:0]   req_command,
   output logic                              req_ready,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   input  wire logic                         csr_write_enable,
   input  wire strm_pkg::dp_status_type      dp_status,
   output strm_pkg::ctrl_cmd_type            cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_QUERY  = 2'd1;
   localparam logic [1:0] S_BREAD  = 2'd2;
   localparam logic [1:0] S_BWRITE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       built_ff, built_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       built_set, built_clr;

   // next state and commands
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      built_set = 1'b0;
      built_clr = 1'b0;
      req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
      accept    = req_valid && req_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_command)
                  strm_pkg::CMD_LOAD: begin
                     cmd.rsp_load = 1'b1;
                     if (dp_status.load_ok) begin
                        cmd.load_write = 1'b1;
                        cmd.rsp_status = strm_pkg::ST_OK;
                        built_clr      = 1'b1;
                     end else begin
                        cmd.rsp_status = strm_pkg::ST_BAD;
                     end
                  end
                  strm_pkg::CMD_BUILD: begin
                     cmd.build_start = 1'b1;
                     state_in        = S_BREAD;
                  end
                  strm_pkg::CMD_QUERY: begin
                     if (!built_ff) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = strm_pkg::ST_NOT_BUILT;
                     end else if (!dp_status.range_ok) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = strm_pkg::ST_BAD;
                     end else begin
                        state_in = S_QUERY;
                     end
                  end
                  default: begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = strm_pkg::ST_BAD;
                  end
               endcase
            end
         end
         S_QUERY: begin
            cmd.rsp_load     = 1'b1;
            cmd.rsp_take_min = 1'b1;
            cmd.rsp_status   = strm_pkg::ST_OK;
            state_in         = S_IDLE;
         end
         S_BREAD: begin
            if (dp_status.level_ok) begin
               cmd.build_read = 1'b1;
               state_in       = S_BWRITE;
            end else begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = strm_pkg::ST_OK;
               built_set      = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_BWRITE: begin
            cmd.build_write = 1'b1;
            state_in        = S_BREAD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // built flag: a register write or an in-range load clears it, a finished build sets it
   always_comb begin
      if (csr_write_enable || built_clr) begin
         built_in = 1'b0;
      end else if (built_set) begin
         built_in = 1'b1;
      end else begin
         built_in = built_ff;
      end
   end

   // result register occupancy
   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         built_ff     <= built_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: sv/strm_dp.sv
`default_nettype none

module strm_dp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire strm_pkg::req_type              req_payload,
   input  wire logic                           csr_write_enable,
   input  wire logic [strm_pkg::COUNT_W-1:0]   csr_write_data,
   input  wire strm_pkg::ctrl_cmd_type         cmd,
   output strm_pkg::dp_status_type             dp_status,
   output strm_pkg::rsp_type                   rsp_payload
);

   localparam int IDX_W   = strm_pkg::IDX_W;
   localparam int COUNT_W = strm_pkg::COUNT_W;
   localparam int LVL_AW  = strm_pkg::LVL_AW;
   localparam int LEVEL_W = strm_pkg::LEVEL_W;
   localparam int ADDR_W  = strm_pkg::ADDR_W;
   localparam int SUM_W   = strm_pkg::SUM_W;
   localparam int VW      = strm_pkg::VALUE_WIDTH;

   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic [IDX_W-1:0]     index_ff, index_in;
   strm_pkg::rsp_type    rsp_ff, rsp_in;

   logic [COUNT_W-1:0]   q_len;
   logic [LEVEL_W-1:0]   q_k;
   logic [COUNT_W-1:0]   q_span;
   logic [COUNT_W-1:0]   q_second_sum;
   logic [SUM_W-1:0]     b_span;
   logic [SUM_W-1:0]     b_half;
   logic [SUM_W-1:0]     b_partner_sum;
   logic [SUM_W-1:0]     b_next_end;
   logic [LEVEL_W-1:0]   b_prev_level;
   logic                 b_next_ok;

   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr, ram_raddr_a, ram_raddr_b;
   logic [VW-1:0]        ram_wdata;
   logic signed [VW-1:0] rd_a, rd_b, min_ab;

   // element count, saturated on write, a written zero taken as one
   always_comb begin
      count_in = count_ff;
      if (csr_write_enable) begin
         if (csr_write_data == '0) begin
            count_in = COUNT_W'(1);
         end else if (csr_write_data > COUNT_W'(strm_pkg::MAX_ELEMENTS)) begin
            count_in = COUNT_W'(strm_pkg::MAX_ELEMENTS);
         end else begin
            count_in = csr_write_data;
         end
      end
   end

   // query geometry
   always_comb begin
      q_len        = {1'b0, req_payload.range_end} - {1'b0, req_payload.range_start}
                     + COUNT_W'(1);
      q_k          = strm_pkg::floor_log2(q_len);
      q_span       = COUNT_W'(1) << q_k;
      q_second_sum = {1'b0, req_payload.range_end} + COUNT_W'(1) - q_span;
   end

   // build walk geometry
   always_comb begin
      b_span        = SUM_W'(1) << level_ff;
      b_half        = b_span >> 1;
      b_partner_sum = SUM_W'(index_ff) + b_half;
      b_next_end    = SUM_W'(index_ff) + SUM_W'(1) + b_span;
      b_prev_level  = level_ff - LEVEL_W'(1);
      b_next_ok     = b_next_end <= SUM_W'(count_ff);
   end

   // status towards the controller
   always_comb begin
      dp_status.load_ok  = {1'b0, req_payload.element_index} < count_ff;
      dp_status.range_ok = (req_payload.range_start <= req_payload.range_end)
                           && ({1'b0, req_payload.range_end} < count_ff)
                           && (q_k < LEVEL_W'(strm_pkg::LEVELS));
      dp_status.level_ok = (level_ff < LEVEL_W'(strm_pkg::LEVELS))
                           && (b_span <= SUM_W'(count_ff));
   end

   // table port addressing
   always_comb begin
      if (cmd.build_read) begin
         ram_raddr_a = {b_prev_level[LVL_AW-1:0], index_ff};
         ram_raddr_b = {b_prev_level[LVL_AW-1:0], b_partner_sum[IDX_W-1:0]};
      end else begin
         ram_raddr_a = {q_k[LVL_AW-1:0], req_payload.range_start};
         ram_raddr_b = {q_k[LVL_AW-1:0], q_second_sum[IDX_W-1:0]};
      end
      ram_we = cmd.build_write || cmd.load_write;
      if (cmd.build_write) begin
         ram_waddr = {level_ff[LVL_AW-1:0], index_ff};
         ram_wdata = min_ab;
      end else begin
         ram_waddr = {LVL_AW'(0), req_payload.element_index};
         ram_wdata = req_payload.element_value;
      end
   end

   assign min_ab = (rd_a <= rd_b) ? rd_a : rd_b;

   // level and index counters of the build
   always_comb begin
      level_in = level_ff;
      index_in = index_ff;
      if (cmd.build_start) begin
         level_in = LEVEL_W'(1);
         index_in = '0;
      end else if (cmd.build_write) begin
         if (b_next_ok) begin
            index_in = index_ff + IDX_W'(1);
         end else begin
            level_in = level_ff + LEVEL_W'(1);
            index_in = '0;
         end
      end
   end

   // result register
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.rsp_load) begin
         rsp_in.minimum = cmd.rsp_take_min ? min_ab : '0;
         rsp_in.status  = cmd.rsp_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_W'(strm_pkg::MAX_ELEMENTS);
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      index_ff <= index_in;
      rsp_ff   <= rsp_in;
   end

   strm_ram #(
      .WIDTH (VW),
      .DEPTH (strm_pkg::RAM_DEPTH)
   ) u_table (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .raddr_a (ram_raddr_a),
      .rdata_a (rd_a),
      .raddr_b (ram_raddr_b),
      .rdata_b (rd_b)
   );

   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// File: sv/sparse_table_range_minimum_top.sv
// loads, bad or unbuilt queries, unused code: result in the cycle after the transfer
// valid queries: registered table read, then the compare loads the result register
// build: result after the last level, each table entry written is a read then a write
// next transfer once the controller is idle and the result register is free or draining
// reset clears the state machine, built flag and result valid; count returns to 1024
// table contents are not cleared by reset
`default_nettype none

module sparse_table_range_minimum_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire strm_pkg::req_type            req_payload,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output strm_pkg::rsp_type                 rsp_payload,
   input  wire logic                         csr_write_enable,
   input  wire logic [strm_pkg::COUNT_W-1:0] csr_write_data
);

   strm_pkg::ctrl_cmd_type  cmd;
   strm_pkg::dp_status_type dp_status;

   strm_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_command      (req_payload.command),
      .req_ready        (req_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .csr_write_enable (csr_write_enable),
      .dp_status        (dp_status),
      .cmd              (cmd)
   );

   strm_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .dp_status        (dp_status),
      .rsp_payload      (rsp_payload)
   );

endmodule

`default_nettype wire

// File: sv/strm_checker.sv
`default_nettype none
`include "sparse_table_range_minimum_top_macros.svh"

module strm_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire strm_pkg::req_type req_payload,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire strm_pkg::rsp_type rsp_payload,
   input wire logic              csr_write_enable
);

   // stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_payload), "stalled result changed")

   // failed results carry a zero minimum
   `ASSERT_IMPLY(a_min_zero, clock, reset,
      rsp_valid && rsp_payload.status != strm_pkg::ST_OK,
      rsp_payload.minimum == '0, "nonzero minimum on failed result")

   // unused code answers next cycle as bad
   `ASSERT_NEXT(a_bad_code, clock, reset,
      req_valid && req_ready && req_payload.command == strm_pkg::CMD_UNUSED,
      rsp_valid && rsp_payload.status == strm_pkg::ST_BAD, "unused code not rejected")

   // query right after a count write sees an unbuilt table
   `ASSERT_NEXT(a_csr_unbuilt, clock, reset,
      $past(csr_write_enable) && req_valid && req_ready
         && req_payload.command == strm_pkg::CMD_QUERY,
      rsp_valid && rsp_payload.status == strm_pkg::ST_NOT_BUILT,
      "query after count write not flagged unbuilt")

endmodule

bind sparse_table_range_minimum_top strm_checker u_checker (.*);

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps

// tracks table contents, built flag and element count; holds the expected results in order
class range_min_scoreboard;
   logic signed [strm_pkg::VALUE_WIDTH-1:0] level_data
      [strm_pkg::LEVELS][strm_pkg::MAX_ELEMENTS];
   bit                                written [strm_pkg::MAX_ELEMENTS];
   bit                                built;
   logic [strm_pkg::COUNT_W-1:0]      count_reg;
   strm_pkg::rsp_type                 expected_q [$];
   int                                mismatch_count;

   function new();
      built = 1'b0;
      count_reg = (strm_pkg::COUNT_W)'(strm_pkg::MAX_ELEMENTS);
      mismatch_count = 0;
      foreach (written[i]) written[i] = 1'b0;
   endfunction

   // zero acts as one, anything above the table size saturates
   function int active_count();
      if (count_reg == 0) return 1;
      if (count_reg > strm_pkg::MAX_ELEMENTS) return strm_pkg::MAX_ELEMENTS;
      return int'(count_reg);
   endfunction

   function int first_unwritten(int n);
      for (int i = 0; i < n; i++) begin
         if (!written[i]) return i;
      end
      return -1;
   endfunction

   function int missing_count(int n);
      int c;
      c = 0;
      for (int i = 0; i < n; i++) begin
         if (!written[i]) c++;
      end
      return c;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function logic signed [strm_pkg::VALUE_WIDTH-1:0] smaller(
      logic signed [strm_pkg::VALUE_WIDTH-1:0] x,
      logic signed [strm_pkg::VALUE_WIDTH-1:0] y);
      return (x <= y) ? x : y;
   endfunction

   // every level whose span fits the count, the top one included
   function void fill_levels();
      int n;
      n = active_count();
      for (int k = 1; k < strm_pkg::LEVELS && (1 << k) <= n; k++) begin
         for (int j = 0; j + (1 << k) <= n; j++) begin
            level_data[k][j] = smaller(level_data[k-1][j], level_data[k-1][j + (1 << (k-1))]);
         end
      end
      built = 1'b1;
   endfunction

   function void note_config(logic [strm_pkg::COUNT_W-1:0] value);
      count_reg = value;
      built = 1'b0;
   endfunction

   // work out the result of one accepted transfer
   function void note_request(strm_pkg::req_type r);
      strm_pkg::rsp_type e;
      int n, span, lvl, second;
      n = active_count();
      e = '0;
      e.status = strm_pkg::ST_OK;
      case (r.command)
         strm_pkg::CMD_LOAD: begin
            if (int'(r.element_index) >= n) begin
               e.status = strm_pkg::ST_BAD;
            end else begin
               level_data[0][r.element_index] = r.element_value;
               written[r.element_index] = 1'b1;
               built = 1'b0;
            end
         end
         strm_pkg::CMD_BUILD: begin
            fill_levels();
         end
         strm_pkg::CMD_QUERY: begin
            // the built flag is checked before the range
            if (!built) begin
               e.status = strm_pkg::ST_NOT_BUILT;
            end else if (r.range_start > r.range_end || int'(r.range_end) >= n) begin
               e.status = strm_pkg::ST_BAD;
            end else begin
               span = int'(r.range_end) - int'(r.range_start) + 1;
               lvl = 0;
               while ((2 << lvl) <= span) lvl++;
               second = int'(r.range_end) + 1 - (1 << lvl);
               e.minimum = smaller(level_data[lvl][r.range_start], level_data[lvl][second]);
            end
         end
         default: begin
            e.status = strm_pkg::ST_BAD;
         end
      endcase
      expected_q.push_back(e);
   endfunction

   task report_mismatch(string what);
      mismatch_count++;
      // keep the log short if everything goes wrong
      if (mismatch_count <= 50) $display("%0t mismatch: %s", $time, what);
   endtask

   task check_response(strm_pkg::rsp_type got);
      strm_pkg::rsp_type e;
      if (expected_q.size() == 0) begin
         report_mismatch($sformatf("result with nothing expected: minimum %0d status %0d",
                                   got.minimum, got.status));
         return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status) begin
         report_mismatch($sformatf("status %0d, expected %0d", got.status, e.status));
      end
      if (got.minimum !== e.minimum) begin
         report_mismatch($sformatf("minimum %0d, expected %0d", got.minimum, e.minimum));
      end
   endtask
endclass

module tb;
   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   strm_pkg::req_type            req_payload = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   strm_pkg::rsp_type            rsp_payload;
   logic                         csr_write_enable = 1'b0;
   logic [strm_pkg::COUNT_W-1:0] csr_write_data = '0;

   int unsigned send_gap_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned hold_serial = 0;
   int unsigned random_items = 0;
   range_min_scoreboard rmq_sb;

   always #1 clock = ~clock;

   sparse_table_range_minimum_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   // result side: check each transfer, stall at random or for a long hold-off
   initial begin : result_side
      int unsigned hold_left;
      int unsigned hold_seen;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) rmq_sb.check_response(rsp_payload);
         if (hold_serial != hold_seen) begin
            hold_seen = hold_serial;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // offer one item, with random gaps first, and wait for its transfer
   task automatic send_item(strm_pkg::req_type r);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      rmq_sb.note_request(r);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (rmq_sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // count writes only while the block is idle
   task automatic write_count(int unsigned value);
      wait_for_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= (strm_pkg::COUNT_W)'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      rmq_sb.note_config((strm_pkg::COUNT_W)'(value));
   endtask

   function automatic strm_pkg::req_type make_req(logic [strm_pkg::CMD_W-1:0] cmd,
                                                  int unsigned idx,
                                                  logic [strm_pkg::VALUE_WIDTH-1:0] value,
                                                  int unsigned a, int unsigned b);
      strm_pkg::req_type r;
      r.command = cmd;
      r.element_index = (strm_pkg::IDX_W)'(idx);
      r.element_value = value;
      r.range_start = (strm_pkg::IDX_W)'(a);
      r.range_end = (strm_pkg::IDX_W)'(b);
      return r;
   endfunction

   function automatic logic [strm_pkg::VALUE_WIDTH-1:0] random_value();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic int unsigned pick_count(int phase);
      case (phase)
         1: return 0;
         3: return 2047;
         5: return 1025;
         7: return 32;
         8: return 1024;
         9: return 2;
         default: return $urandom_range(48, 3);
      endcase
   endfunction

   // mostly fill, build and query in order; the rest is noise
   function automatic strm_pkg::req_type next_random_item();
      strm_pkg::req_type r;
      int n, roll, gap_idx, t, a, b;
      n = rmq_sb.active_count();
      gap_idx = rmq_sb.first_unwritten(n);
      roll = $urandom_range(99);
      t = $urandom_range(n - 1);
      r.command = strm_pkg::CMD_UNUSED;
      r.element_index = (strm_pkg::IDX_W)'($urandom);
      r.element_value = random_value();
      r.range_start = (strm_pkg::IDX_W)'($urandom);
      r.range_end = (strm_pkg::IDX_W)'($urandom);
      if (!rmq_sb.built && gap_idx >= 0 && roll < 88) begin
         // every element in use must be loaded before a build
         r.command = strm_pkg::CMD_LOAD;
         r.element_index = (strm_pkg::IDX_W)'(rmq_sb.written[t] ? gap_idx : t);
      end else if (!rmq_sb.built && gap_idx < 0 && roll < 55) begin
         r.command = strm_pkg::CMD_BUILD;
      end else if (rmq_sb.built && roll < 72) begin
         a = $urandom_range(n - 1);
         b = $urandom_range(n - 1);
         case ($urandom_range(3))
            0: b = a;
            1: begin
               a = 0;
               b = n - 1;
            end
            default: if (a > b) begin
               t = a;
               a = b;
               b = t;
            end
         endcase
         r.command = strm_pkg::CMD_QUERY;
         r.range_start = (strm_pkg::IDX_W)'(a);
         r.range_end = (strm_pkg::IDX_W)'(b);
      end else if (roll < (n > 256 ? 73 : 80)) begin
         // rewrite an element in use, rebuilds are slow on large counts
         r.command = strm_pkg::CMD_LOAD;
         r.element_index = (strm_pkg::IDX_W)'(t);
      end else begin
         case ($urandom_range(3))
            0: r.command = strm_pkg::CMD_UNUSED;
            1: r.command = strm_pkg::CMD_QUERY;
            2: begin
               r.command = strm_pkg::CMD_QUERY;
               a = $urandom_range(strm_pkg::MAX_ELEMENTS - 1, 1);
               r.range_start = (strm_pkg::IDX_W)'(a);
               r.range_end = (strm_pkg::IDX_W)'($urandom_range(a - 1));
            end
            default: if (n < strm_pkg::MAX_ELEMENTS) begin
               r.command = strm_pkg::CMD_LOAD;
               r.element_index = (strm_pkg::IDX_W)'($urandom_range(strm_pkg::MAX_ELEMENTS - 1, n));
            end
         endcase
      end
      return r;
   endfunction

   initial begin : stimulus
      int phase;
      int n_items;
      rmq_sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // query before any build, bad range on an unbuilt table, unused code
      send_item(make_req(strm_pkg::CMD_QUERY, 0, '0, 0, 1023));
      send_item(make_req(strm_pkg::CMD_QUERY, 0, '0, 5, 2));
      send_item(make_req(strm_pkg::CMD_UNUSED, 1023, '1, 1023, 1023));

      // count of zero acts as one; out of range load keeps the table built
      write_count(0);
      send_item(make_req(strm_pkg::CMD_LOAD, 0, 32'h8000_0000, 0, 0));
      send_item(make_req(strm_pkg::CMD_BUILD, 0, '0, 0, 0));
      send_item(make_req(strm_pkg::CMD_LOAD, 1023, 32'h7FFF_FFFF, 0, 0));
      send_item(make_req(strm_pkg::CMD_QUERY, 0, '0, 0, 0));
      send_item(make_req(strm_pkg::CMD_QUERY, 0, '0, 0, 1));
      send_item(make_req(strm_pkg::CMD_QUERY, 0, '0, 1, 0));

      // two elements: top level, reload clears the built flag
      write_count(2);
      send_item(make_req(strm_pkg::CMD_LOAD, 1, 32'h7FFF_FFFF, 0, 0));
      send_item(make_req(strm_pkg::CMD_BUILD, 0, '0, 0, 0));
      send_item(make_req(strm_pkg::CMD_QUERY, 0, '0, 0, 1));
      send_item(make_req(strm_pkg::CMD_QUERY, 0, '0, 1, 1));
      send_item(make_req(strm_pkg::CMD_QUERY, 0, '0, 1023, 1023));
      send_item(make_req(strm_pkg::CMD_LOAD, 0, '0, 0, 0));
      send_item(make_req(strm_pkg::CMD_QUERY, 0, '0, 0, 1));
      send_item(make_req(strm_pkg::CMD_BUILD, 0, '0, 0, 0));
      send_item(make_req(strm_pkg::CMD_QUERY, 0, '0, 0, 1));

      // random phases, each with its own count and idling pattern
      phase = 0;
      while (random_items < 700 || phase < 10) begin
         write_count(pick_count(phase));
         case (phase % 4)
            0: begin
               send_gap_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               send_gap_pct = 53;
               stall_pct <= 0;
            end
            2: begin
               send_gap_pct = 0;
               stall_pct <= 53;
            end
            default: begin
               send_gap_pct = 7;
               stall_pct <= 7;
            end
         endcase
         n_items = 40 + $urandom_range(30);
         // small tables get filled and built; full-size ones see loads and noise only
         if (rmq_sb.active_count() <= 64) begin
            n_items += rmq_sb.missing_count(rmq_sb.active_count()) * 5 / 4;
         end
         for (int i = 0; i < n_items; i++) begin
            // long receiver hold-off while items keep coming
            if (phase == 2 && i == 20) hold_serial <= hold_serial + 1;
            send_item(next_random_item());
            random_items++;
         end
         phase++;
      end

      wait_for_results();
      if (rmq_sb.mismatch_count == 0) begin
         $display("[sparse_table_range_minimum_top] OK");
      end else begin
         $display("[sparse_table_range_minimum_top] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("[sparse_table_range_minimum_top] ERROR");
      $finish;
   end
endmodule
